// ----- design/blb_pkg.sv -----
// Shared types, constants and helpers for the backend load balancer.
// No dependencies; used by every module of the block.
package blb_pkg;

  localparam int BACKENDS_DEF   = 8;
  localparam int CONN_WIDTH_DEF = 16;
  localparam int IDX_W          = 3;
  localparam int CNT_W          = 4;
  localparam int WGT_W          = 8;
  localparam int TOT_W          = 11;
  localparam int CW_W           = 16;

  localparam logic [1:0] REG_ALG   = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_WGT   = 2'd2;
  localparam logic [1:0] REG_TOTAL = 2'd3;

  localparam logic [1:0] ALG_RR   = 2'd0;
  localparam logic [1:0] ALG_SWRR = 2'd1;
  localparam logic [1:0] ALG_LC   = 2'd2;

  localparam logic [1:0] REQ_PICK    = 2'd0;
  localparam logic [1:0] REQ_HEALTH  = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GRANT,
    OP_SETTLE,
    OP_HEALTH,
    OP_RELEASE
  } cmd_op_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic             health;
  } cmd_t;

  // Best candidate so far, handed from cell to cell during a scan.
  typedef struct packed {
    logic                   valid;
    logic [IDX_W-1:0]       idx;
    logic                   healthy;
    logic signed [CW_W-1:0] cw;
  } tok_t;

  function automatic logic signed [CW_W-1:0] sat16(input logic signed [CW_W:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[CW_W-1:0];
    end
  endfunction

endpackage

// ----- design/blb_cell.sv -----
// One backend cell: current weight, health flag and open-connection count.
// Depends on blb_pkg; chained by backend_load_balancer_core.
module blb_cell #(
  parameter int IDX        = 0,
  parameter int CONN_WIDTH = blb_pkg::CONN_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        algorithm,
  input  logic [blb_pkg::CNT_W-1:0]         active_n,
  input  logic [blb_pkg::WGT_W-1:0]         weight,
  input  logic [blb_pkg::TOT_W-1:0]         weight_total,
  input  blb_pkg::cmd_t                     cmd,
  input  blb_pkg::tok_t                     tok_in,
  input  logic [CONN_WIDTH-1:0]             conn_in,
  output blb_pkg::tok_t                     tok_out,
  output logic [CONN_WIDTH-1:0]             conn_out,
  output logic                              healthy
);
  import blb_pkg::*;

  logic signed [CW_W-1:0] cw;
  logic signed [CW_W-1:0] cw_next;
  logic signed [CW_W-1:0] cw_add;
  logic [CONN_WIDTH-1:0]  conn;
  logic [CONN_WIDTH-1:0]  conn_next;
  logic [CONN_WIDTH-1:0]  conn_out_next;
  logic                   healthy_next;
  logic                   in_use;
  logic                   part;
  logic                   hit;
  tok_t                   tok_next;

  assign in_use = (CNT_W'(IDX) < active_n);
  assign part   = in_use && healthy;
  assign cw_add = sat16($signed({cw[CW_W-1], cw}) + $signed({9'd0, weight}));

  always_comb begin
    cw_next       = cw;
    conn_next     = conn;
    healthy_next  = healthy;
    tok_next      = tok_in;
    conn_out_next = conn_in;
    hit           = 1'b0;

    if (tok_in.valid) begin
      if (algorithm == ALG_SWRR && (IDX == 0 || part)) begin
        cw_next = cw_add;
      end
      if (IDX == 0) begin
        hit = 1'b1;
      end else if (algorithm == ALG_SWRR) begin
        hit = part && (cw_add > tok_in.cw);
      end else begin
        hit = part && (conn < conn_in);
      end
      if (hit) begin
        tok_next.idx     = IDX_W'(IDX);
        tok_next.healthy = healthy;
        tok_next.cw      = (algorithm == ALG_SWRR) ? cw_add : cw;
        conn_out_next    = conn;
      end
    end

    if (cmd.idx == IDX_W'(IDX)) begin
      case (cmd.op)
        OP_GRANT: begin
          if (conn != '1) conn_next = conn + CONN_WIDTH'(1);
        end
        OP_SETTLE: begin
          if (healthy) begin
            cw_next = sat16($signed({cw[CW_W-1], cw}) - $signed({6'd0, weight_total}));
            if (conn != '1) conn_next = conn + CONN_WIDTH'(1);
          end else begin
            cw_next = sat16($signed({cw[CW_W-1], cw}) - $signed({9'd0, weight}));
          end
        end
        OP_HEALTH:  healthy_next = cmd.health;
        OP_RELEASE: begin
          if (conn != '0) conn_next = conn - CONN_WIDTH'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cw      <= '0;
      conn    <= '0;
      healthy <= 1'b1;
      tok_out <= '0;
    end else begin
      cw      <= cw_next;
      conn    <= conn_next;
      healthy <= healthy_next;
      tok_out <= tok_next;
    end
    conn_out <= conn_out_next;
  end

endmodule

// ----- design/blb_ctrl.sv -----
// Request sequencer: round robin pick, scan launch, state commands, result register.
// Depends on blb_pkg; drives the cell chain of backend_load_balancer_core.
module blb_ctrl #(
  parameter int BACKENDS = blb_pkg::BACKENDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic [blb_pkg::IDX_W-1:0]   backend_index,
  input  logic                        health_value,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        granted,
  output logic [blb_pkg::IDX_W-1:0]   chosen_index,
  input  logic [1:0]                  algorithm,
  input  logic [blb_pkg::CNT_W-1:0]   active_n,
  input  logic [BACKENDS-1:0]         health,
  input  blb_pkg::tok_t               tok_end,
  output blb_pkg::tok_t               start,
  output blb_pkg::cmd_t               cmd
);
  import blb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t           state;
  logic [IDX_W-1:0] rr_ptr;
  logic [IDX_W-1:0] rr_p;
  logic [IDX_W-1:0] rr_ptr_next;
  logic [7:0]       health8;
  logic             rr_ok;
  logic             idx_ok;
  logic             accept;
  logic             res_take;
  logic             res_g;
  logic [IDX_W-1:0] res_idx;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign res_take  = res_valid && !res_stall;
  assign health8   = 8'(health);
  assign idx_ok    = ({1'b0, backend_index} < CNT_W'(BACKENDS));

  always_comb begin
    rr_p        = ({1'b0, rr_ptr} >= active_n) ? '0 : rr_ptr;
    rr_ptr_next = (({1'b0, rr_p} + CNT_W'(1)) >= active_n) ? '0 : rr_p + IDX_W'(1);
    rr_ok       = health8[rr_p];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rr_ptr    <= '0;
      res_valid <= 1'b0;
      cmd       <= '0;
      start     <= '0;
    end else begin
      cmd.op      <= OP_NONE;
      start.valid <= 1'b0;
      if (res_take) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_g   <= 1'b0;
            res_idx <= '0;
            state   <= S_DONE;
            case (req_type)
              REQ_PICK: begin
                case (algorithm)
                  ALG_RR: begin
                    rr_ptr <= rr_ptr_next;
                    if (rr_ok) begin
                      cmd.op  <= OP_GRANT;
                      cmd.idx <= rr_p;
                      res_g   <= 1'b1;
                      res_idx <= rr_p;
                    end
                  end
                  ALG_SWRR, ALG_LC: begin
                    start.valid <= 1'b1;
                    state       <= S_SCAN;
                  end
                  default: ;
                endcase
              end
              REQ_HEALTH: begin
                if (idx_ok) begin
                  cmd.op     <= OP_HEALTH;
                  cmd.idx    <= backend_index;
                  cmd.health <= health_value;
                end
              end
              REQ_RELEASE: begin
                if (idx_ok) begin
                  cmd.op  <= OP_RELEASE;
                  cmd.idx <= backend_index;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (tok_end.valid) begin
            state <= S_DONE;
            if (algorithm == ALG_SWRR) begin
              cmd.op  <= OP_SETTLE;
              cmd.idx <= tok_end.idx;
            end else if (tok_end.healthy) begin
              cmd.op  <= OP_GRANT;
              cmd.idx <= tok_end.idx;
            end
            if (tok_end.healthy) begin
              res_g   <= 1'b1;
              res_idx <= tok_end.idx;
            end
          end
        end
        S_DONE: begin
          if (!res_valid || res_take) begin
            res_valid    <= 1'b1;
            granted      <= res_g;
            chosen_index <= res_idx;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/backend_load_balancer_core.sv -----
// Backend load balancer top level: configuration registers and a chain of backend cells.
// Depends on blb_pkg, blb_cell and blb_ctrl.
//
//   beat      handshake              payload
//   request   req_valid / req_stall  req_type, backend_index, health_value
//   result    res_valid / res_stall  granted, chosen_index
//   config    wr_en                  wr_index, wr_data
//
// Round robin picks, health updates and releases pass from the done state into the result
// register. Weighted and least-connection picks first scan the cell chain: the
// candidate beat steps through one cell per cycle. One request is in flight at a time.
// Synchronous reset: every backend healthy, connection counts and current weights zero.
// One result may wait under res_stall while the next request is taken; that request
// then holds in the sequencer, stalling input, until the result register drains.
module backend_load_balancer_core #(
  parameter int BACKENDS   = blb_pkg::BACKENDS_DEF,
  parameter int CONN_WIDTH = blb_pkg::CONN_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic [blb_pkg::IDX_W-1:0]   backend_index,
  input  logic                        health_value,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        granted,
  output logic [blb_pkg::IDX_W-1:0]   chosen_index,
  input  logic                        wr_en,
  input  logic [1:0]                  wr_index,
  input  logic [63:0]                 wr_data
);
  import blb_pkg::*;

  logic [1:0]            algorithm;
  logic [CNT_W-1:0]      used_count;
  logic [63:0]           backend_weights;
  logic [TOT_W-1:0]      weight_total;
  logic [CNT_W-1:0]      active_n;
  logic [BACKENDS-1:0]   health;
  tok_t                  start;
  cmd_t                  cmd;
  tok_t                  tok_chain [BACKENDS];
  logic [CONN_WIDTH-1:0] conn_chain [BACKENDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm       <= ALG_RR;
      used_count      <= CNT_W'(8);
      backend_weights <= 64'h0101010101010101;
      weight_total    <= TOT_W'(8);
    end else if (wr_en) begin
      case (wr_index)
        REG_ALG:   algorithm       <= wr_data[1:0];
        REG_COUNT: used_count      <= wr_data[CNT_W-1:0];
        REG_WGT:   backend_weights <= wr_data;
        REG_TOTAL: weight_total    <= wr_data[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (used_count == '0) begin
      active_n = CNT_W'(1);
    end else if (used_count > CNT_W'(BACKENDS)) begin
      active_n = CNT_W'(BACKENDS);
    end else begin
      active_n = used_count;
    end
  end

  blb_ctrl #(
    .BACKENDS(BACKENDS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .backend_index(backend_index),
    .health_value (health_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .granted      (granted),
    .chosen_index (chosen_index),
    .algorithm    (algorithm),
    .active_n     (active_n),
    .health       (health),
    .tok_end      (tok_chain[BACKENDS-1]),
    .start        (start),
    .cmd          (cmd)
  );

  for (genvar i = 0; i < BACKENDS; i++) begin : g_cell
    tok_t                  tok_in;
    logic [CONN_WIDTH-1:0] conn_in;

    if (i == 0) begin : g_head
      assign tok_in  = start;
      assign conn_in = '0;
    end else begin : g_body
      assign tok_in  = tok_chain[i-1];
      assign conn_in = conn_chain[i-1];
    end

    blb_cell #(
      .IDX       (i),
      .CONN_WIDTH(CONN_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .algorithm   (algorithm),
      .active_n    (active_n),
      .weight      (backend_weights[WGT_W*i +: WGT_W]),
      .weight_total(weight_total),
      .cmd         (cmd),
      .tok_in      (tok_in),
      .conn_in     (conn_in),
      .tok_out     (tok_chain[i]),
      .conn_out    (conn_chain[i]),
      .healthy     (health[i])
    );
  end

`ifndef ASSERT_OFF
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !granted |-> chosen_index == '0)
    else $error("refused result carries a nonzero index");

  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && granted |-> ({1'b0, chosen_index} < CNT_W'(BACKENDS)))
    else $error("granted index beyond the backend row");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    tok_chain[BACKENDS-1].valid |-> req_stall)
    else $error("candidate left the chain while the sequencer was idle");

  a_scan_from_start: assert property (@(posedge clk) disable iff (rst)
    start.valid |-> !tok_chain[BACKENDS-1].valid)
    else $error("scan launched while another was still in the chain");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for backend_load_balancer_core: round robin, smooth weighted and
// least-connection picks, health and release beats, predicted in request order in SV.
// Depends on blb_pkg and backend_load_balancer_core from the design folder.
module tb_top;
  import blb_pkg::*;

  localparam int NB          = BACKENDS_DEF;
  localparam int CONN_W      = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 24;
  localparam int WATCHDOG    = 1000;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] ALG_UNKNOWN = 2'd3;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] chosen;
  } lb_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  logic [1:0]       req_type;
  logic [IDX_W-1:0] backend_index;
  logic             health_value;
  logic             res_valid;
  logic             res_stall;
  logic             granted;
  logic [IDX_W-1:0] chosen_index;
  logic             wr_en;
  logic [1:0]       wr_index;
  logic [63:0]      wr_data;

  // balancer state as the block should hold it
  logic [1:0]              cfg_alg;
  logic [3:0]              cfg_count;
  logic [63:0]             cfg_weights;
  logic [TOT_W-1:0]        cfg_total;
  logic [IDX_W-1:0]        rr_ptr;
  logic signed [CW_W-1:0]  cur_weight [NB];
  logic                    healthy [NB];
  logic [CONN_W-1:0]       open_conns [NB];

  lb_result_t awaited[$];
  int         fail_count = 0;
  int         idle_run = 0;
  bit         quiet = 1'b0;
  bit         hold_off_req = 1'b0;

  backend_load_balancer_core #(
    .BACKENDS   (NB),
    .CONN_WIDTH (CONN_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .backend_index (backend_index),
    .health_value  (health_value),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .granted       (granted),
    .chosen_index  (chosen_index),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [CW_W-1:0] clamp_cw(int v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return CW_W'(v);
  endfunction

  function automatic int weight_at(int i);
    return int'(cfg_weights[8*i +: 8]);
  endfunction

  function automatic lb_result_t balance_request(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                                 logic hv);
    lb_result_t r;
    int n;
    int p;
    int win;
    logic ok;
    r = '0;
    ok = 1'b0;
    win = 0;
    n = (cfg_count == 0) ? 1 : (cfg_count > NB) ? NB : int'(cfg_count);
    if (kind == REQ_PICK) begin
      case (cfg_alg)
        ALG_RR: begin
          p = (int'(rr_ptr) >= n) ? 0 : int'(rr_ptr);
          rr_ptr = (p + 1 >= n) ? '0 : IDX_W'(p + 1);
          if (healthy[p]) begin
            ok = 1'b1;
            win = p;
          end
        end
        ALG_SWRR: begin
          cur_weight[0] = clamp_cw(int'(cur_weight[0]) + weight_at(0));
          for (int i = 1; i < n; i++) begin
            if (healthy[i]) begin
              cur_weight[i] = clamp_cw(int'(cur_weight[i]) + weight_at(i));
              if (cur_weight[i] > cur_weight[win]) win = i;
            end
          end
          if (healthy[win]) begin
            cur_weight[win] = clamp_cw(int'(cur_weight[win]) - int'(cfg_total));
            ok = 1'b1;
          end else begin
            cur_weight[win] = clamp_cw(int'(cur_weight[win]) - weight_at(win));
          end
        end
        ALG_LC: begin
          for (int i = 1; i < n; i++) begin
            if (healthy[i] && open_conns[i] < open_conns[win]) win = i;
          end
          ok = healthy[win];
        end
        default: ;
      endcase
      if (ok) begin
        if (open_conns[win] != '1) open_conns[win] = open_conns[win] + 1'b1;
        r.granted = 1'b1;
        r.chosen = IDX_W'(win);
      end
    end else if (kind == REQ_HEALTH) begin
      healthy[idx] = hv;
    end else if (kind == REQ_RELEASE) begin
      if (open_conns[idx] != '0) open_conns[idx] = open_conns[idx] - 1'b1;
    end
    return r;
  endfunction

  function automatic int idle_cycles();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_req(logic [1:0] kind, logic [IDX_W-1:0] idx, logic hv);
    int gap;
    req_valid <= 1'b1;
    req_type <= kind;
    backend_index <= idx;
    health_value <= hv;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    awaited.push_back(balance_request(kind, idx, hv));
    gap = quiet ? 0 : idle_cycles();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int count);
    int r;
    logic [1:0] kind;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) kind = REQ_PICK;
      else if (r < 78) kind = REQ_HEALTH;
      else if (r < 95) kind = REQ_RELEASE;
      else kind = REQ_UNKNOWN;
      send_req(kind, IDX_W'($urandom_range(0, NB - 1)), $urandom_range(0, 3) != 0);
    end
    quiet = 1'b0;
  endtask

  // wait for every outstanding result, then let the block go quiet
  task automatic settle();
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] which, logic [63:0] value);
    wr_en <= 1'b1;
    wr_index <= which;
    wr_data <= value;
    case (which)
      REG_ALG:   cfg_alg = value[1:0];
      REG_COUNT: cfg_count = value[3:0];
      REG_WGT:   cfg_weights = value;
      REG_TOTAL: cfg_total = value[TOT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper bits carry noise
  task automatic configure(logic [1:0] alg, logic [3:0] count, logic [63:0] weights,
                           logic [TOT_W-1:0] total);
    logic [63:0] junk;
    settle();
    junk = {$urandom, $urandom};
    write_reg(REG_ALG, {junk[63:2], alg});
    write_reg(REG_COUNT, {junk[63:4], count});
    write_reg(REG_WGT, weights);
    write_reg(REG_TOTAL, {junk[63:TOT_W], total});
  endtask

  function automatic logic [TOT_W-1:0] weight_sum(logic [3:0] count, logic [63:0] weights);
    int n;
    int s;
    n = (count == 0) ? 1 : (count > NB) ? NB : int'(count);
    s = 0;
    for (int i = 0; i < n; i++) s += int'(weights[8*i +: 8]);
    return TOT_W'(s);
  endfunction

  task automatic test_round_robin();
    repeat (3) send_req(REQ_PICK, 3'd5, 1'b0);
    send_req(REQ_HEALTH, 3'd7, 1'b0);
    send_req(REQ_RELEASE, 3'd1, 1'b1);
    send_req(REQ_RELEASE, 3'd1, 1'b0);
    send_req(REQ_UNKNOWN, 3'd7, 1'b1);
    // pointer now past the smaller backend count
    configure(ALG_RR, 4'd2, 64'h0101010101010101, 11'd2);
    repeat (2) send_req(REQ_PICK, 3'd0, 1'b1);
    configure(ALG_RR, 4'd0, 64'h0101010101010101, 11'd1);
    send_req(REQ_PICK, 3'd2, 1'b1);
    configure(ALG_RR, 4'd15, 64'h0101010101010101, 11'd8);
    send_req(REQ_PICK, 3'd2, 1'b1);
  endtask

  task automatic test_weighted();
    configure(ALG_SWRR, 4'd3, 64'hFF0102030405_06C8, 11'd210);
    // backend 0 unhealthy yet still in the running
    send_req(REQ_HEALTH, 3'd0, 1'b0);
    repeat (2) send_req(REQ_PICK, 3'd3, 1'b0);
    send_req(REQ_HEALTH, 3'd0, 1'b1);
    repeat (2) send_req(REQ_PICK, 3'd4, 1'b1);
  endtask

  task automatic test_least_connections();
    configure(ALG_LC, 4'd8, 64'h0, 11'd0);
    repeat (3) send_req(REQ_PICK, 3'd6, 1'b0);
    send_req(REQ_RELEASE, 3'd0, 1'b0);
    send_req(REQ_HEALTH, 3'd0, 1'b0);
    repeat (2) send_req(REQ_PICK, 3'd6, 1'b1);
    send_req(REQ_HEALTH, 3'd0, 1'b1);
  endtask

  task automatic test_unknown_algorithm();
    configure(ALG_UNKNOWN, 4'd8, 64'hFFFFFFFFFFFFFFFF, 11'h7ff);
    repeat (2) send_req(REQ_PICK, 3'd7, 1'b1);
  endtask

  task automatic test_backpressure();
    configure(ALG_RR, 4'd8, 64'h0101010101010101, 11'd8);
    quiet = 1'b1;
    hold_off_req = 1'b1;
    repeat (12) send_req(REQ_PICK, IDX_W'($urandom_range(0, NB - 1)), $urandom_range(0, 1));
    quiet = 1'b0;
  endtask

  task automatic test_connection_saturation();
    configure(ALG_RR, 4'd1, 64'h0101010101010101, 11'd1);
    send_req(REQ_HEALTH, 3'd0, 1'b1);
    repeat (258) send_req(REQ_PICK, IDX_W'($urandom_range(0, NB - 1)), $urandom_range(0, 1));
    repeat (2) send_req(REQ_RELEASE, 3'd0, 1'b0);
    send_req(REQ_PICK, 3'd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [3:0] count;
    logic [63:0] weights;
    configure(ALG_RR, 4'($urandom_range(1, 8)), {$urandom, $urandom}, 11'($urandom));
    send_random(15);
    // weights pile up towards the positive limit
    configure(ALG_SWRR, 4'd8, 64'hFFFFFFFFFFFFFFFF, 11'd0);
    send_random(200);
    // winner drains towards the negative limit
    configure(ALG_SWRR, 4'd1, 64'h0, 11'h7ff);
    send_random(40);
    for (int k = 0; k < 3; k++) begin
      count = 4'($urandom_range(0, 15));
      weights = {$urandom, $urandom};
      configure(ALG_SWRR, count, weights, weight_sum(count, weights));
      send_random(10);
    end
    configure(ALG_LC, 4'($urandom_range(2, 7)), {$urandom, $urandom}, 11'($urandom));
    send_random(15);
    configure(ALG_LC, 4'd8, {$urandom, $urandom}, 11'($urandom));
    send_random(10);
    configure(ALG_UNKNOWN, 4'($urandom_range(0, 15)), {$urandom, $urandom}, 11'($urandom));
    send_random(5);
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        hold = idle_cycles();
      end
      res_stall <= (hold > 0);
    end
  end

  always @(posedge clk) begin : result_check
    lb_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: granted=%0d chosen=%0d", granted, chosen_index);
      end else begin
        want = awaited.pop_front();
        if (granted !== want.granted || chosen_index !== want.chosen) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: granted exp %0d got %0d, chosen exp %0d got %0d",
                     want.granted, granted, want.chosen, chosen_index);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req_type <= REQ_PICK;
    backend_index <= '0;
    health_value <= 1'b0;
    wr_en <= 1'b0;
    wr_index <= REG_ALG;
    wr_data <= '0;
    cfg_alg = ALG_RR;
    cfg_count = 4'd8;
    cfg_weights = 64'h0101010101010101;
    cfg_total = 11'd8;
    rr_ptr = '0;
    for (int i = 0; i < NB; i++) begin
      cur_weight[i] = '0;
      healthy[i] = 1'b1;
      open_conns[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_round_robin();
    test_weighted();
    test_least_connections();
    test_unknown_algorithm();
    test_backpressure();
    test_connection_saturation();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
